// ===== sv/tsdf_pkg.sv =====
// Shared constants, codes and helpers for the triangle distance-field pixel block.
// No dependencies; imported by tsdf_front, tsdf_back, the top level and the testbench.
`default_nettype none

package tsdf_pkg;

	// default fraction bits of the fixed-point geometry
	localparam int FRAC_BITS_DEF = 8;

	// geometry constants, 16 fraction bits where marked
	localparam longint SQRT3_Q16        = 113512;
	localparam longint R_OVER_SQRT3_Q16 = 2421583;
	localparam int     TRI_RADIUS       = 64;
	localparam int     GRID_CENTER      = 127;

	// spread register reset value
	localparam logic [7:0] SPREAD_RESET = 8'd16;

	// queue depths (powers of two)
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	// sign of the folded y coordinate
	typedef enum logic [1:0] {
		SGN_ZERO = 2'd0,
		SGN_POS  = 2'd1,
		SGN_NEG  = 2'd2
	} sign_t;

	// round a 16-fraction-bit constant to nearest into f fraction bits
	function automatic longint q16_to_qf(input longint c, input int f);
		return ((c <<< f) + 64'sd32768) >>> 16;
	endfunction

endpackage

`default_nettype wire

// ===== sv/tsdf_fifo.sv =====
// Small register queue, used between the front and back and for results.
// Depends on nothing; DEPTH must be a power of two.
`default_nettype none

module tsdf_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         wr_en,
	input  wire logic [W-1:0] wr_data,
	input  wire logic         rd_en,
	output logic [W-1:0]      rd_data,
	output logic              full,
	output logic              empty
);
	localparam int AW = $clog2(DEPTH);

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign full    = (count_q == (AW+1)'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/tsdf_front.sv =====
// Front part: takes pixel items, folds and reflects them into the triangle frame,
// clamps x and forms the squared length. Uses tsdf_pkg.
`default_nettype none

module tsdf_front #(
	parameter int F = tsdf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                in_valid,
	input  wire logic [7:0]          pixel_x,
	input  wire logic [7:0]          pixel_y,
	output logic                     out_valid,
	output logic [2*F+17:0]          out_sq,
	output tsdf_pkg::sign_t          out_sgn
);
	import tsdf_pkg::*;

	localparam int PW  = F + 10;
	localparam int KW  = F + 2;
	localparam int MW  = KW + PW;
	localparam int SW  = 2*F + 13;
	localparam int SQW = 2*F + 18;

	localparam logic signed [KW-1:0] K_C    = KW'(q16_to_qf(SQRT3_Q16, F));
	localparam logic signed [PW-1:0] RK_C   = PW'(q16_to_qf(R_OVER_SQRT3_Q16, F));
	localparam logic signed [PW-1:0] RAD_C  = PW'(TRI_RADIUS);
	localparam logic signed [PW-1:0] LO_C   = PW'(-(longint'(2*TRI_RADIUS) <<< F));
	localparam logic signed [9:0]    CTR_C  = 10'(GRID_CENTER);
	localparam logic [SW-1:0]        HALF_C = SW'(1) << F;

	logic [5:0] vld_q;

	logic signed [9:0]    xf, yf, ax;
	logic signed [PW-1:0] px_c, py_c;
	logic signed [PW-1:0] px_s1, py_s1;

	logic signed [MW-1:0] kpx_s2, kpy_s2;
	logic signed [PW-1:0] px_s2, py_s2;

	logic signed [SW-1:0] pxs, pys, tst;
	logic signed [SW-1:0] a_s3, b_s3;
	logic signed [PW-1:0] px_s3, py_s3;
	logic                 refl_s3;

	logic signed [PW-1:0] nx, ny, pxc;
	logic signed [PW-1:0] pxc_s4, py_s4;
	sign_t                sgn_c, sgn_s4, sgn_s5, sgn_s6;

	logic signed [2*PW-1:0] pxx, pyy;
	logic [SQW-1:0]         pxx_s5, pyy_s5, sq_s6;

	// round to nearest, ties away from zero, dropping F+1 bits
	function automatic logic signed [PW-1:0] rnd(input logic signed [SW-1:0] v);
		logic [SW-1:0]        mag;
		logic [SW-1:0]        sh;
		logic signed [PW-1:0] r;
		mag = v[SW-1] ? SW'(-v) : SW'(v);
		sh  = (mag + HALF_C) >> (F + 1);
		r   = signed'(PW'(sh));
		return v[SW-1] ? -r : r;
	endfunction

	// fold x and move to the triangle frame
	always_comb begin
		xf   = signed'({2'b00, pixel_x}) - CTR_C;
		yf   = signed'({2'b00, pixel_y}) - CTR_C;
		ax   = xf[9] ? -xf : xf;
		px_c = (PW'(ax) - RAD_C) <<< F;
		py_c = (PW'(yf) <<< F) + RK_C;
	end

	// edge test terms and reflected candidates
	always_comb begin
		pxs = SW'(px_s2) <<< F;
		pys = SW'(py_s2) <<< F;
		tst = pxs + SW'(kpy_s2);
	end

	// reflect, clamp x, and classify y
	always_comb begin
		nx = refl_s3 ? rnd(a_s3) : px_s3;
		ny = refl_s3 ? rnd(b_s3) : py_s3;
		if (nx > 0) begin
			pxc = nx;
		end else if (nx < LO_C) begin
			pxc = nx - LO_C;
		end else begin
			pxc = '0;
		end
		if (ny > 0) begin
			sgn_c = SGN_POS;
		end else if (ny < 0) begin
			sgn_c = SGN_NEG;
		end else begin
			sgn_c = SGN_ZERO;
		end
	end

	assign pxx = pxc_s4 * pxc_s4;
	assign pyy = py_s4 * py_s4;

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[4:0], in_valid};
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (en) begin
			px_s1   <= px_c;
			py_s1   <= py_c;
			kpx_s2  <= K_C * px_s1;
			kpy_s2  <= K_C * py_s1;
			px_s2   <= px_s1;
			py_s2   <= py_s1;
			refl_s3 <= (tst > 0);
			a_s3    <= pxs - SW'(kpy_s2);
			b_s3    <= -SW'(kpx_s2) - pys;
			px_s3   <= px_s2;
			py_s3   <= py_s2;
			pxc_s4  <= pxc;
			py_s4   <= ny;
			sgn_s4  <= sgn_c;
			pxx_s5  <= pxx[SQW-1:0];
			pyy_s5  <= pyy[SQW-1:0];
			sgn_s5  <= sgn_s4;
			sq_s6   <= pxx_s5 + pyy_s5;
			sgn_s6  <= sgn_s5;
		end
	end

	assign out_valid = vld_q[5];
	assign out_sq    = sq_s6;
	assign out_sgn   = sgn_s6;

endmodule

`default_nettype wire

// ===== sv/tsdf_back.sv =====
// Back part: pipelined square root, distance offset, band test and divide by spread.
// Uses tsdf_pkg.
`default_nettype none

module tsdf_back #(
	parameter int F = tsdf_pkg::FRAC_BITS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          edge_spread,
	input  wire logic                in_valid,
	input  wire logic [2*F+17:0]     in_sq,
	input  wire tsdf_pkg::sign_t     in_sgn,
	output logic                     in_take,
	input  wire logic                out_full,
	output logic                     out_valid,
	output logic [7:0]               out_byte
);
	import tsdf_pkg::*;

	localparam int SQW = 2*F + 18;
	localparam int RW  = SQW / 2;
	localparam int RMW = RW + 3;
	localparam int DW  = F + 12;
	localparam int NW  = F + 16;

	logic en;

	logic [RW-1:0]  sr_vld_s;
	logic [RMW-1:0] sr_rem_s  [RW];
	logic [RW-1:0]  sr_root_s [RW];
	logic [SQW-1:0] sr_rad_s  [RW];
	sign_t          sr_sgn_s  [RW];

	logic signed [DW-1:0] half_c, dist_c, sq_c;
	logic signed [DW-1:0] dist_s1;
	logic                 vld_s1;

	logic          vld_s2, fix_s2;
	logic [7:0]    fixv_s2;
	logic [NW-1:0] num_s2;

	logic [7:0]    dv_vld_s;
	logic [7:0]    dv_fix_s  [8];
	logic [7:0]    dv_fixv_s [8];
	logic [NW-1:0] dv_rem_s  [8];
	logic [7:0]    dv_q_s    [8];

	assign en      = !out_full;
	assign in_take = en && in_valid;

	// square root, one result bit per stage
	for (genvar g = 0; g < RW; g++) begin : g_sqrt
		logic           v_in;
		logic [RMW-1:0] rem_in, cur, trial;
		logic [RW-1:0]  root_in;
		logic [SQW-1:0] rad_in;
		sign_t          sgn_in;

		if (g == 0) begin : g_first
			assign v_in    = in_valid;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = in_sq;
			assign sgn_in  = in_sgn;
		end else begin : g_next
			assign v_in    = sr_vld_s[g-1];
			assign rem_in  = sr_rem_s[g-1];
			assign root_in = sr_root_s[g-1];
			assign rad_in  = sr_rad_s[g-1];
			assign sgn_in  = sr_sgn_s[g-1];
		end

		assign cur   = {rem_in[RMW-3:0], rad_in[SQW-1:SQW-2]};
		assign trial = RMW'({root_in, 2'b01});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_vld_s[g] <= 1'b0;
			end else if (en) begin
				sr_vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (cur >= trial) begin
					sr_rem_s[g]  <= cur - trial;
					sr_root_s[g] <= {root_in[RW-2:0], 1'b1};
				end else begin
					sr_rem_s[g]  <= cur;
					sr_root_s[g] <= {root_in[RW-2:0], 1'b0};
				end
				sr_rad_s[g] <= rad_in << 2;
				sr_sgn_s[g] <= sgn_in;
			end
		end
	end

	// offset the length by half the spread
	always_comb begin
		half_c = signed'(DW'(edge_spread) << (F - 1));
		sq_c   = signed'(DW'(sr_root_s[RW-1]));
		case (sr_sgn_s[RW-1])
			SGN_POS: dist_c = half_c - sq_c;
			SGN_NEG: dist_c = half_c + sq_c;
			default: dist_c = half_c;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sr_vld_s[RW-1];
			vld_s2 <= vld_s1;
		end
	end

	// band test and scaled numerator
	always_ff @(posedge clk) begin
		if (en) begin
			dist_s1 <= dist_c;
			num_s2  <= NW'((dist_s1 <<< 8) - dist_s1);
			if (dist_s1 >= signed'(DW'(edge_spread) << F)) begin
				fix_s2  <= 1'b1;
				fixv_s2 <= 8'd255;
			end else if (dist_s1 <= 0) begin
				fix_s2  <= 1'b1;
				fixv_s2 <= 8'd0;
			end else begin
				fix_s2  <= 1'b0;
				fixv_s2 <= 8'd0;
			end
		end
	end

	// restoring divide by the spread, one quotient bit per stage
	for (genvar j = 0; j < 8; j++) begin : g_div
		logic          v_in, f_in;
		logic [7:0]    fv_in, q_in;
		logic [NW-1:0] r_in, dsh;

		if (j == 0) begin : g_first
			assign v_in  = vld_s2;
			assign f_in  = fix_s2;
			assign fv_in = fixv_s2;
			assign r_in  = num_s2;
			assign q_in  = '0;
		end else begin : g_next
			assign v_in  = dv_vld_s[j-1];
			assign f_in  = dv_fix_s[j-1][0];
			assign fv_in = dv_fixv_s[j-1];
			assign r_in  = dv_rem_s[j-1];
			assign q_in  = dv_q_s[j-1];
		end

		assign dsh = NW'(edge_spread) << (F + 7 - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (en) begin
				dv_vld_s[j] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_fix_s[j]  <= {7'd0, f_in};
				dv_fixv_s[j] <= fv_in;
				if (r_in >= dsh) begin
					dv_rem_s[j] <= r_in - dsh;
					dv_q_s[j]   <= q_in | (8'd1 << (7 - j));
				end else begin
					dv_rem_s[j] <= r_in;
					dv_q_s[j]   <= q_in;
				end
			end
		end
	end

	assign out_valid = en && dv_vld_s[7];
	assign out_byte  = dv_fix_s[7][0] ? dv_fixv_s[7] : dv_q_s[7];

endmodule

`default_nettype wire

// ===== sv/triangle_sdf_pixel.sv =====
// Top level of the triangle distance-field pixel block: front, queues, back.
// Uses tsdf_pkg, tsdf_front, tsdf_fifo and tsdf_back.
//
//  channel   ports                      handshake
//  input     pixel_x, pixel_y           push / full
//  result    field_byte                 empty / pop
//  config    cfg_data                   cfg_we (no wait)
//
// One pixel per clock is sustained while neither queue is full; an item passes
// through six geometry stages, the middle queue, FRAC_BITS+9 square-root stages
// (one root bit each), two offset stages, eight divide stages and the result
// queue before empty goes low.
// Reset clears all valids and queues; the spread register returns to 16.
// A full result queue stalls the back; a full middle queue stalls the front.
`default_nettype none

module triangle_sdf_pixel #(
	parameter int FRAC_BITS = tsdf_pkg::FRAC_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] pixel_x,
	input  wire logic [7:0] pixel_y,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      field_byte,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_data
);
	import tsdf_pkg::*;

	localparam int SQW = 2*FRAC_BITS + 18;
	localparam int MW  = SQW + 2;

	logic [7:0]     edge_spread_q;
	logic           en_f;
	logic           f_valid;
	logic [SQW-1:0] f_sq;
	sign_t          f_sgn;
	logic           mid_full, mid_empty, mid_take;
	logic [MW-1:0]  mid_data;
	logic           out_full, b_valid;
	logic [7:0]     b_byte;

	// spread register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_spread_q <= SPREAD_RESET;
		end else if (cfg_we) begin
			edge_spread_q <= cfg_data;
		end
	end

	// hold the front while the middle queue is full
	assign en_f = !mid_full;
	assign full = mid_full;

	tsdf_front #(.F(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en_f),
		.in_valid  (push && !mid_full),
		.pixel_x   (pixel_x),
		.pixel_y   (pixel_y),
		.out_valid (f_valid),
		.out_sq    (f_sq),
		.out_sgn   (f_sgn)
	);

	tsdf_fifo #(.W(MW), .DEPTH(MID_DEPTH)) u_mid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (f_valid && en_f),
		.wr_data ({f_sgn, f_sq}),
		.rd_en   (mid_take),
		.rd_data (mid_data),
		.full    (mid_full),
		.empty   (mid_empty)
	);

	tsdf_back #(.F(FRAC_BITS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.edge_spread (edge_spread_q),
		.in_valid    (!mid_empty),
		.in_sq       (mid_data[SQW-1:0]),
		.in_sgn      (sign_t'(mid_data[MW-1:SQW])),
		.in_take     (mid_take),
		.out_full    (out_full),
		.out_valid   (b_valid),
		.out_byte    (b_byte)
	);

	tsdf_fifo #(.W(8), .DEPTH(OUT_DEPTH)) u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (b_valid),
		.wr_data (b_byte),
		.rd_en   (pop),
		.rd_data (field_byte),
		.full    (out_full),
		.empty   (empty)
	);

endmodule

`default_nettype wire

// ===== tb/sv/triangle_sdf_pixel_tb.sv =====
// Testbench for triangle_sdf_pixel: drives pixels through the queue handshake,
// predicts each field byte in fixed point and checks results in order.
// Depends on tsdf_pkg and the triangle_sdf_pixel RTL.
`default_nettype none

class field_scoreboard;
	logic [7:0] spread;
	logic [7:0] pending[$];
	int errors;

	function new();
		spread = tsdf_pkg::SPREAD_RESET;
		errors = 0;
	endfunction

	// isqrt, floor
	function automatic longint root_floor(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	// halve-and-shift back to Q.F, ties away from zero
	function automatic longint round_shift(longint v, int s);
		longint h;
		h = longint'(64'd1 << (s - 1));
		if (v >= 0) return (v + h) >>> s;
		return -((-v + h) >>> s);
	endfunction

	function automatic logic [7:0] field_value(logic [7:0] x, logic [7:0] y);
		localparam int F = 8;
		longint one, k, rk, xf, yf, ax, px, py, nx, ny, lo, sq_q, len, dist_v;
		one = longint'(1) << F;
		k = (tsdf_pkg::SQRT3_Q16 * one + 32768) / 65536;
		rk = (tsdf_pkg::R_OVER_SQRT3_Q16 * one + 32768) / 65536;
		xf = longint'(x) - tsdf_pkg::GRID_CENTER;
		yf = longint'(y) - tsdf_pkg::GRID_CENTER;
		ax = xf < 0 ? -xf : xf;
		px = (ax - tsdf_pkg::TRI_RADIUS) * one;
		py = yf * one + rk;
		lo = -2 * tsdf_pkg::TRI_RADIUS * one;
		sq_q = longint'(spread) * one;
		// reflect across the edge
		if (px * one + k * py > 0) begin
			nx = round_shift(px * one - k * py, F + 1);
			ny = round_shift(-k * px - py * one, F + 1);
			px = nx;
			py = ny;
		end
		// clamp x
		if (px > 0) px = px;
		else if (px < lo) px = px - lo;
		else px = 0;
		len = root_floor(longint'(px * px + py * py));
		dist_v = longint'(spread) * (one / 2);
		if (py > 0) dist_v = dist_v - len;
		else if (py < 0) dist_v = dist_v + len;
		if (dist_v >= sq_q) return 8'd255;
		if (dist_v <= 0) return 8'd0;
		return 8'((dist_v * 255) / sq_q);
	endfunction

	function void note_pixel(logic [7:0] x, logic [7:0] y);
		pending.push_back(field_value(x, y));
	endfunction

	function void check_byte(logic [7:0] got);
		logic [7:0] want;
		if (pending.size() == 0) begin
			$error("field_byte: unexpected item, actual %0d", got);
			errors++;
		end else begin
			want = pending.pop_front();
			if (want !== got) begin
				$error("field_byte: expected %0d actual %0d", want, got);
				errors++;
			end
		end
	endfunction
endclass

module triangle_sdf_pixel_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic pop = 1'b0;
	logic [7:0] pixel_x = '0;
	logic [7:0] pixel_y = '0;
	logic cfg_we = 1'b0;
	logic [7:0] cfg_data = '0;
	logic full, empty;
	logic [7:0] field_byte;
	bit calm = 1'b0;
	bit sink_run = 1'b1;
	field_scoreboard board;

	triangle_sdf_pixel u_dut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.pixel_x(pixel_x), .pixel_y(pixel_y), .empty(empty), .pop(pop),
		.field_byte(field_byte), .cfg_we(cfg_we), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// hard stop
	initial begin
		#20ms;
		$display("triangle_sdf_pixel_tb NOT OK");
		$finish;
	end

	// drain results, stalling in bursts
	always @(posedge clk) begin
		int gap;
		if (arst_n) begin
			if (pop && !empty) board.check_byte(field_byte);
			if (!calm && sink_run && $urandom_range(0, 15) == 0) begin
				gap = $urandom_range(1, 18);
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
				if (pop && !empty) board.check_byte(field_byte);
			end
			pop <= 1'b1;
		end
	end

	task automatic send_pixel(logic [7:0] x, logic [7:0] y);
		int gap;
		if (!calm && $urandom_range(0, 15) == 0) begin
			gap = $urandom_range(1, 18);
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		pixel_x <= x;
		pixel_y <= y;
		@(posedge clk);
		while (full) @(posedge clk);
		board.note_pixel(x, y);
	endtask

	task automatic settle_then_write(logic [7:0] value);
		push <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.spread = value;
	endtask

	task automatic random_pixels(int n);
		int c, r;
		for (int i = 0; i < n; i++) begin
			// mostly near the triangle, some anywhere
			if ($urandom_range(0, 3) == 0) begin
				send_pixel(8'($urandom), 8'($urandom));
			end else begin
				c = $urandom_range(40, 215);
				r = $urandom_range(40, 215);
				send_pixel(8'(c), 8'(r));
			end
		end
	endtask

	initial begin
		logic [7:0] spreads[5];
		spreads = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd64};
		board = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: corners, centre, fold line, edges
		send_pixel(8'd0, 8'd0);
		send_pixel(8'd255, 8'd255);
		send_pixel(8'd0, 8'd255);
		send_pixel(8'd255, 8'd0);
		send_pixel(8'd127, 8'd127);
		send_pixel(8'd127, 8'd0);
		send_pixel(8'd127, 8'd255);
		send_pixel(8'd191, 8'd164);
		send_pixel(8'd63, 8'd164);
		send_pixel(8'd127, 8'd90);
		send_pixel(8'd170, 8'd127);
		send_pixel(8'd128, 8'd200);
		send_pixel(8'd85, 8'd170);
		send_pixel(8'd200, 8'd100);
		random_pixels(50);
		foreach (spreads[s]) begin
			settle_then_write(spreads[s]);
			send_pixel(8'd127, 8'd127);
			send_pixel(8'd127, 8'd164);
			send_pixel(8'd191, 8'd164);
			random_pixels(60);
		end
		settle_then_write(8'd16);
		calm = 1'b1;
		random_pixels(60);
		push <= 1'b0;
		@(posedge clk);
		while (board.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (board.errors == 0) begin
			$display("triangle_sdf_pixel_tb OK");
		end else begin
			$display("triangle_sdf_pixel_tb NOT OK");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== triangle_sdf_pixel.f =====
sv/tsdf_pkg.sv
sv/tsdf_fifo.sv
sv/tsdf_front.sv
sv/tsdf_back.sv
sv/triangle_sdf_pixel.sv
tb/sv/triangle_sdf_pixel_tb.sv
